### hw/rtl/timer_table_scan_expire_core_assert.svh
// Assertion macros for the timer table core.
// Uses the clk and rst_n names of the including module.
`ifndef TIMER_TABLE_SCAN_EXPIRE_CORE_ASSERT_SVH
`define TIMER_TABLE_SCAN_EXPIRE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define TTSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TTSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ttse_pkg.sv
// Shared types and constants for the timer table core.
// No dependencies.
package ttse_pkg;

  localparam int NUM_TIMERS = 32;
  localparam int IDX_W      = $clog2(NUM_TIMERS);      // memory address width
  localparam int CNT_W      = $clog2(NUM_TIMERS + 1);  // high-water / scan counter
  localparam int IDXF_W     = 6;                       // index field width
  localparam int CMP_W      = IDXF_W + 1;
  localparam int TICK_W     = 64;
  localparam int ACT_W      = 3;
  localparam int ST_W       = 3;

  localparam logic [TICK_W-1:0] TICK_INVALID = '1;

  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC  = 3'd0,
    ACT_FREE   = 3'd1,
    ACT_SET    = 3'd2,
    ACT_RESET  = 3'd3,
    ACT_CANCEL = 3'd4,
    ACT_TICK   = 3'd5,
    ACT_EXPIRE = 3'd6,
    ACT_READ   = 3'd7
  } action_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK          = 3'd0,
    ST_NONE_FREE   = 3'd1,
    ST_BAD_INDEX   = 3'd2,
    ST_ACTIVE      = 3'd3,
    ST_BAD_TICK    = 3'd4,
    ST_WRONG_STATE = 3'd5,
    ST_IGNORED     = 3'd6,
    ST_EXPIRED     = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    TTS_IDLE,
    TTS_EXEC,
    TTS_SCAN,
    TTS_SUM
  } state_t;

  // Free-list link: tail flag and next entry.
  typedef struct packed {
    logic              tail;
    logic [IDXF_W-1:0] next;
  } link_t;

endpackage

### hw/rtl/timer_table_scan_expire_core.sv
// Timer table core: one-shot timers, LIFO free list, expiry scan.
// Depends on ttse_pkg and timer_table_scan_expire_core_assert.svh.
//
// A request is taken only while the core is idle. Alloc, free, set, reset,
// cancel, tick, read and an expire that is not yet due first read the expiry
// and link memories, then check, write back and load the output register,
// waiting while that register is still held by a stall. A due expire walks
// the entries below the high-water mark through the expiry memory's single
// read port, one entry per cycle while no due result waits on an output
// stall, overlapping the read of one entry with the check and write-back of
// the one before. Each expired timer is reported in index order, followed
// by one summary result carrying the new earliest due tick.
module timer_table_scan_expire_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ttse_pkg::ACT_W-1:0]    in_action,
  input  logic [ttse_pkg::IDXF_W-1:0]   in_timer_index,
  input  logic [ttse_pkg::TICK_W-1:0]   in_tick_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ttse_pkg::ST_W-1:0]     out_status,
  output logic [ttse_pkg::IDXF_W-1:0]   out_result_index,
  output logic [ttse_pkg::TICK_W-1:0]   out_result_tick,
  output logic                          out_last
);
  import ttse_pkg::*;

  // Control state
  state_t              state_r, state_nxt;
  logic                free_empty_r, free_empty_nxt;
  logic [IDXF_W-1:0]   free_head_r, free_head_nxt;
  logic [CNT_W-1:0]    high_water_r, high_water_nxt;
  logic [TICK_W-1:0]   now_tick_r, now_tick_nxt;
  logic [TICK_W-1:0]   earliest_r, earliest_nxt;
  logic [CNT_W-1:0]    scan_idx_r, scan_idx_nxt;
  logic                chk_vld_r, chk_vld_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Request and scan payload
  action_t             act_r;
  logic [IDXF_W-1:0]   idx_r;
  logic [TICK_W-1:0]   tick_r;
  logic [IDX_W-1:0]    chk_idx_r, chk_idx_nxt;
  logic [TICK_W-1:0]   scan_min_r, scan_min_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [IDXF_W-1:0]   out_index_r, out_index_nxt;
  logic [TICK_W-1:0]   out_tick_r, out_tick_nxt;
  logic                out_last_r, out_last_nxt;

  // Memories and their valid bits (an entry never written reads as reset value)
  logic [TICK_W-1:0]   exp_mem [NUM_TIMERS];
  link_t               link_mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] exp_vld_r, link_vld_r;

  logic                exp_re, exp_we;
  logic [IDX_W-1:0]    exp_raddr, exp_waddr;
  logic [TICK_W-1:0]   exp_wdata;
  logic [TICK_W-1:0]   exp_rdata_r;
  logic                exp_rvld_r;
  logic [TICK_W-1:0]   exp_rd;

  logic                link_re, link_we;
  logic [IDX_W-1:0]    link_raddr, link_waddr, link_raddr_r;
  link_t               link_wdata, link_rdata_r, link_rd, link_dflt;
  logic                link_rvld_r;

  // Shared decode
  logic                accept, out_free, emit;
  logic                head_oor;
  logic [IDX_W-1:0]    alloc_h;
  logic [CNT_W-1:0]    alloc_hw;
  logic                idx_ok, inactive, tick_bad;
  logic                chk_due, scan_more, scan_hold;

  assign accept   = in_valid && (state_r == TTS_IDLE);
  assign in_stall = (state_r != TTS_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign head_oor = (CMP_W'(free_head_r) >= CMP_W'(NUM_TIMERS));
  assign alloc_h  = head_oor ? '0 : free_head_r[IDX_W-1:0];
  assign alloc_hw = CNT_W'(alloc_h) + CNT_W'(1);

  assign idx_ok   = (CMP_W'(idx_r) < CMP_W'(high_water_r));
  assign exp_rd   = exp_rvld_r ? exp_rdata_r : '0;
  assign inactive = (exp_rd == TICK_INVALID);
  assign tick_bad = (tick_r == TICK_INVALID);

  assign link_dflt.tail = (CMP_W'(link_raddr_r) == CMP_W'(NUM_TIMERS - 1));
  assign link_dflt.next = IDXF_W'(CMP_W'(link_raddr_r) + CMP_W'(1));
  assign link_rd        = link_rvld_r ? link_rdata_r : link_dflt;

  assign chk_due   = (exp_rd <= now_tick_r);
  assign scan_more = (scan_idx_r < high_water_r);
  assign scan_hold = chk_vld_r && chk_due && !out_free;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      TTS_IDLE: begin
        if (accept) state_nxt = TTS_EXEC;
      end
      TTS_EXEC: begin
        if (out_free) begin
          if (act_r == ACT_EXPIRE && earliest_r <= now_tick_r) state_nxt = TTS_SCAN;
          else state_nxt = TTS_IDLE;
        end
      end
      TTS_SCAN: begin
        if (!scan_hold && !scan_more) state_nxt = TTS_SUM;
      end
      TTS_SUM: begin
        if (out_free) state_nxt = TTS_IDLE;
      end
      default: state_nxt = TTS_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    free_empty_nxt = free_empty_r;
    free_head_nxt  = free_head_r;
    high_water_nxt = high_water_r;
    now_tick_nxt   = now_tick_r;
    earliest_nxt   = earliest_r;
    scan_idx_nxt   = scan_idx_r;
    chk_vld_nxt    = chk_vld_r;
    chk_idx_nxt    = chk_idx_r;
    scan_min_nxt   = scan_min_r;
    emit           = 1'b0;
    out_status_nxt = ST_OK;
    out_index_nxt  = '0;
    out_tick_nxt   = '0;
    out_last_nxt   = 1'b1;
    exp_re         = 1'b0;
    exp_raddr      = in_timer_index[IDX_W-1:0];
    exp_we         = 1'b0;
    exp_waddr      = idx_r[IDX_W-1:0];
    exp_wdata      = TICK_INVALID;
    link_re        = 1'b0;
    link_raddr     = alloc_h;
    link_we        = 1'b0;
    link_waddr     = idx_r[IDX_W-1:0];
    link_wdata     = '{tail: free_empty_r, next: free_head_r};

    unique case (state_r)
      TTS_IDLE: begin
        if (accept) begin
          exp_re  = 1'b1;
          link_re = 1'b1;
        end
      end

      TTS_EXEC: begin
        if (out_free) begin
          emit = 1'b1;
          unique case (act_r)
            ACT_ALLOC: begin
              if (free_empty_r) begin
                out_status_nxt = ST_NONE_FREE;
              end else begin
                free_empty_nxt = link_rd.tail;
                free_head_nxt  = link_rd.next;
                exp_we         = 1'b1;
                exp_waddr      = alloc_h;
                if (alloc_hw > high_water_r) high_water_nxt = alloc_hw;
                out_index_nxt  = IDXF_W'(alloc_h);
              end
            end
            ACT_FREE: begin
              priority if (!idx_ok) out_status_nxt = ST_BAD_INDEX;
              else if (!inactive) out_status_nxt = ST_ACTIVE;
              else begin
                link_we        = 1'b1;
                free_head_nxt  = idx_r;
                free_empty_nxt = 1'b0;
              end
            end
            ACT_SET, ACT_RESET: begin
              priority if (tick_bad) out_status_nxt = ST_BAD_TICK;
              else if (!idx_ok) out_status_nxt = ST_BAD_INDEX;
              else if ((act_r == ACT_RESET) == inactive) out_status_nxt = ST_WRONG_STATE;
              else begin
                exp_we    = 1'b1;
                exp_wdata = tick_r;
                if (tick_r < earliest_r) earliest_nxt = tick_r;
              end
            end
            ACT_CANCEL: begin
              priority if (!idx_ok) out_status_nxt = ST_BAD_INDEX;
              else if (inactive) out_status_nxt = ST_WRONG_STATE;
              else exp_we = 1'b1;
            end
            ACT_TICK: begin
              priority if (tick_bad) out_status_nxt = ST_BAD_TICK;
              else if (tick_r <= now_tick_r) out_status_nxt = ST_IGNORED;
              else now_tick_nxt = tick_r;
            end
            ACT_EXPIRE: begin
              if (earliest_r > now_tick_r) begin
                out_status_nxt = ST_IGNORED;
                out_tick_nxt   = earliest_r;
              end else begin
                // start the walk; nothing to report yet
                emit         = 1'b0;
                scan_idx_nxt = '0;
                chk_vld_nxt  = 1'b0;
                scan_min_nxt = TICK_INVALID;
              end
            end
            ACT_READ: begin
              out_tick_nxt = now_tick_r;
            end
            default: ;
          endcase
        end
      end

      TTS_SCAN: begin
        if (!scan_hold) begin
          if (chk_vld_r) begin
            if (chk_due) begin
              // disarm and report the due timer
              emit           = 1'b1;
              out_status_nxt = ST_EXPIRED;
              out_index_nxt  = IDXF_W'(chk_idx_r);
              out_tick_nxt   = exp_rd;
              out_last_nxt   = 1'b0;
              exp_we         = 1'b1;
              exp_waddr      = chk_idx_r;
            end else if (exp_rd < scan_min_r) begin
              scan_min_nxt = exp_rd;
            end
          end
          if (scan_more) begin
            exp_re       = 1'b1;
            exp_raddr    = scan_idx_r[IDX_W-1:0];
            chk_idx_nxt  = scan_idx_r[IDX_W-1:0];
            chk_vld_nxt  = 1'b1;
            scan_idx_nxt = scan_idx_r + CNT_W'(1);
          end else begin
            chk_vld_nxt = 1'b0;
          end
        end
      end

      TTS_SUM: begin
        if (out_free) begin
          emit         = 1'b1;
          out_tick_nxt = scan_min_r;
          earliest_nxt = scan_min_r;
        end
      end

      default: ;
    endcase

    out_valid_nxt = emit || (out_valid_r && out_stall);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= TTS_IDLE;
      free_empty_r <= 1'b0;
      free_head_r  <= '0;
      high_water_r <= '0;
      now_tick_r   <= '0;
      earliest_r   <= TICK_INVALID;
      scan_idx_r   <= '0;
      chk_vld_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      exp_vld_r    <= '0;
      link_vld_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      free_empty_r <= free_empty_nxt;
      free_head_r  <= free_head_nxt;
      high_water_r <= high_water_nxt;
      now_tick_r   <= now_tick_nxt;
      earliest_r   <= earliest_nxt;
      scan_idx_r   <= scan_idx_nxt;
      chk_vld_r    <= chk_vld_nxt;
      out_valid_r  <= out_valid_nxt;
      if (exp_we) exp_vld_r[exp_waddr] <= 1'b1;
      if (link_we) link_vld_r[link_waddr] <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= action_t'(in_action);
      idx_r  <= in_timer_index;
      tick_r <= in_tick_value;
    end
    chk_idx_r  <= chk_idx_nxt;
    scan_min_r <= scan_min_nxt;
    if (emit) begin
      out_status_r <= out_status_nxt;
      out_index_r  <= out_index_nxt;
      out_tick_r   <= out_tick_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  // Expiry memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (exp_we) exp_mem[exp_waddr] <= exp_wdata;
    if (exp_re) begin
      exp_rdata_r <= exp_mem[exp_raddr];
      exp_rvld_r  <= exp_vld_r[exp_raddr];
    end
  end

  // Free-list link memory
  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    if (link_re) begin
      link_rdata_r <= link_mem[link_raddr];
      link_rvld_r  <= link_vld_r[link_raddr];
      link_raddr_r <= link_raddr;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_index = out_index_r;
  assign out_result_tick  = out_tick_r;
  assign out_last         = out_last_r;

`include "timer_table_scan_expire_core_assert.svh"

  `TTSE_ASSERT_NEXT(a_accept_to_exec, accept, state_r == TTS_EXEC, "request not executed")
  `TTSE_ASSERT_NOW(a_hw_bound, 1'b1, CMP_W'(high_water_r) <= CMP_W'(NUM_TIMERS),
                   "high-water mark out of range")
  `TTSE_ASSERT_NOW(a_expired_not_last, out_valid_r && out_status_r == ST_EXPIRED,
                   !out_last_r, "expired result marked last")
  `TTSE_ASSERT_NOW(a_head_in_range, !free_empty_r && state_r != TTS_IDLE, !head_oor,
                   "free head out of range with list not empty")

endmodule
